// File: design/swfd_pkg.sv
// Shared types and constants for the sync word frame deframer.
package swfd_pkg;

  // Word that opens every frame
  localparam logic [15:0] SYNC_WORD = 16'hDEAD;

  // Meaning of word_kind on a result beat
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_CRC     = 1'b1;

  // One result beat
  typedef struct packed {
    logic        word_kind;
    logic [15:0] msg_type;
    logic [15:0] seq_number;
    logic [15:0] payload_length;
    logic [15:0] data_word;
    logic        last_of_frame;
  } result_t;

endpackage

// File: design/sync_word_frame_deframer.sv
// Input beats are held in the input register, result beats in the result register.
// Throughput: one word per cycle; the input register advances whenever the
// skid stage behind the result register is empty.
// Reset (rst_n, synchronous, active low): parser back to hunt, header fields,
// word count and own_id cleared, input and result stages emptied.
// Frames for other destinations are consumed with no result beats.
module sync_word_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_rx_word,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_word_kind,
  output logic [15:0] out_msg_type,
  output logic [15:0] out_seq_number,
  output logic [15:0] out_payload_length,
  output logic [15:0] out_data_word,
  output logic        out_last_of_frame
);
  import swfd_pkg::*;

  logic        own_id_r;
  logic [15:0] own_id_val_r;
  logic        in_valid_r;
  logic [15:0] in_word_r;
  logic        in_fe_r;
  logic        skid_full;
  logic        proc;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= 1'b0;
      own_id_val_r <= '0;
    end else if (cfg_wr_en) begin
      own_id_r     <= 1'b1;
      own_id_val_r <= cfg_wr_data;
    end
  end

  // Process the held beat whenever the output side has room
  assign proc     = in_valid_r & ~skid_full;
  assign in_stall = in_valid_r & skid_full;
  assign accept   = in_valid & ~in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word_r <= in_rx_word;
      in_fe_r   <= in_frame_end;
    end
  end

  swfd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_fire      (proc),
    .item_word      (in_word_r),
    .item_frame_end (in_fe_r),
    .own_id         (own_id_val_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  swfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_word_kind      = out_data.word_kind;
  assign out_msg_type       = out_data.msg_type;
  assign out_seq_number     = out_data.seq_number;
  assign out_payload_length = out_data.payload_length;
  assign out_data_word      = out_data.data_word;
  assign out_last_of_frame  = out_data.last_of_frame;

`ifndef SYNTH
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid))
    else $error("input stalled with no beat held");

  a_cfg_written: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (own_id_r && own_id_val_r == $past(cfg_wr_data)))
    else $error("own_id write lost");

  a_beat_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !accept) |=> !in_valid_r)
    else $error("processed beat not released from input register");
`endif

endmodule

// File: design/swfd_parser.sv
// Frame parser: phase sequencer, held header fields and result formation.
module swfd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_fire,
  input  logic [15:0]      item_word,
  input  logic             item_frame_end,
  input  logic [15:0]      own_id,
  output logic             res_valid,
  output swfd_pkg::result_t res
);
  import swfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_DEST    = 3'd1,
    PH_TYPE    = 3'd2,
    PH_SEQ     = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRC     = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        for_us_r, for_us_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [15:0] remain_dec;

  assign remain_dec = remain_r - 16'd1;

  // Advance the phase, capture header words and form result beats
  always_comb begin
    phase_nxt          = phase_r;
    for_us_nxt         = for_us_r;
    type_nxt           = type_r;
    seq_nxt            = seq_r;
    len_nxt            = len_r;
    remain_nxt         = remain_r;
    res_valid          = 1'b0;
    res.word_kind      = KIND_PAYLOAD;
    res.msg_type       = type_r;
    res.seq_number     = seq_r;
    res.payload_length = len_r;
    res.data_word      = item_word;
    res.last_of_frame  = 1'b0;
    if (item_fire) begin
      if (item_frame_end) begin
        phase_nxt  = PH_HUNT;
        for_us_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          PH_DEST: begin
            for_us_nxt = (item_word == own_id);
            phase_nxt  = PH_TYPE;
          end
          PH_TYPE: begin
            type_nxt  = item_word;
            phase_nxt = PH_SEQ;
          end
          PH_SEQ: begin
            seq_nxt   = item_word;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            len_nxt    = item_word;
            remain_nxt = item_word;
            phase_nxt  = (item_word == 16'd0) ? PH_CRC : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            remain_nxt = remain_dec;
            if (remain_dec == 16'd0) begin
              phase_nxt = PH_CRC;
            end
            res_valid = for_us_r;
          end
          PH_CRC: begin
            phase_nxt         = PH_HUNT;
            for_us_nxt        = 1'b0;
            res_valid         = for_us_r;
            res.word_kind     = KIND_CRC;
            res.last_of_frame = 1'b1;
          end
          default: begin
            // Hunt, and any code that means nothing
            phase_nxt = (item_word == SYNC_WORD) ? PH_DEST : PH_HUNT;
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      for_us_r <= 1'b0;
      type_r   <= '0;
      seq_r    <= '0;
      len_r    <= '0;
      remain_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      for_us_r <= for_us_nxt;
      type_r   <= type_nxt;
      seq_r    <= seq_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
    end
  end

`ifndef SYNTH
  a_payload_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (remain_r != 16'd0))
    else $error("payload phase with no words remaining");

  a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (item_fire && !item_frame_end && for_us_r))
    else $error("result formed without an accepted frame word");

  a_hunt_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item_frame_end) |=> (phase_r == PH_HUNT && !for_us_r))
    else $error("frame end did not return parser to hunt");
`endif

endmodule

// File: design/swfd_out_buf.sv
// Result register with a skid stage behind it.
module swfd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swfd_pkg::result_t push_data,
  output logic              skid_full,
  output logic              out_valid,
  input  logic              out_stall,
  output swfd_pkg::result_t out_data
);
  import swfd_pkg::*;

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign pop       = main_valid_r & ~out_stall;
  assign skid_full = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Control: drain the skid stage first, then take new beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

`ifndef SYNTH
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid stage holds a beat with the result register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("beat pushed while skid stage full");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (main_valid_r && main_r == $past(skid_r)))
    else $error("skid beat not moved into result register");
`endif

endmodule
